// ===== rtl/tsa_pkg.sv =====
// Shared types and constants for the degree-11 Taylor sine pipeline.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tsa_pkg;

    localparam int TOP_EXPONENT = 11;
    localparam int FRAC_BITS    = 28;
    localparam int INNER_FRAC   = 48;

    localparam int TOP_ODD   = (TOP_EXPONENT % 2 != 0) ? TOP_EXPONENT : TOP_EXPONENT - 1;
    localparam int NUM_STEPS = (TOP_ODD - 1) / 2;
    localparam int MAX_STEPS = 7;

    localparam int ANGLE_W = 32;
    localparam int MAG_W   = 63;   // magnitudes clamp at 2^62
    localparam int OPND_W  = 64;
    localparam int PROD_W  = 128;

    localparam int TERM_SHIFT = 2 * FRAC_BITS;

    localparam logic [MAG_W-1:0]  LIM62     = MAG_W'(1) << 62;
    localparam logic [MAG_W-1:0]  ONE_INNER = MAG_W'(1) << INNER_FRAC;
    localparam logic [PROD_W-1:0] TERM_RND  = PROD_W'(1) << (TERM_SHIFT - 1);
    localparam logic [PROD_W-1:0] FIN_RND   = PROD_W'(1) << (INNER_FRAC - 1);

    // Per-sample lane that rides alongside every stage.
    typedef struct packed {
        logic               x_neg;
        logic [ANGLE_W-1:0] x_mag;
        logic [MAG_W-1:0]   x2;
    } t_side;

    // Division by (n-1)*n done as multiply by ceil(2^shift/d), then shift.
    typedef struct packed {
        logic [6:0]        half;
        logic [OPND_W-1:0] recip;
        logic [6:0]        shift;
    } t_div;

    function automatic int step_div(input int step);
        int n;
        n = TOP_ODD - 2 * step;
        return (n >= 3) ? (n - 1) * n : 6;
    endfunction

    localparam int DIV_0 = step_div(0);
    localparam int DIV_1 = step_div(1);
    localparam int DIV_2 = step_div(2);
    localparam int DIV_3 = step_div(3);
    localparam int DIV_4 = step_div(4);
    localparam int DIV_5 = step_div(5);
    localparam int DIV_6 = step_div(6);

    localparam int SH_0 = 62 + $clog2(DIV_0);
    localparam int SH_1 = 62 + $clog2(DIV_1);
    localparam int SH_2 = 62 + $clog2(DIV_2);
    localparam int SH_3 = 62 + $clog2(DIV_3);
    localparam int SH_4 = 62 + $clog2(DIV_4);
    localparam int SH_5 = 62 + $clog2(DIV_5);
    localparam int SH_6 = 62 + $clog2(DIV_6);

    localparam logic [PROD_W-1:0] RECIP_0 =
        ((PROD_W'(1) << SH_0) + PROD_W'(DIV_0 - 1)) / PROD_W'(DIV_0);
    localparam logic [PROD_W-1:0] RECIP_1 =
        ((PROD_W'(1) << SH_1) + PROD_W'(DIV_1 - 1)) / PROD_W'(DIV_1);
    localparam logic [PROD_W-1:0] RECIP_2 =
        ((PROD_W'(1) << SH_2) + PROD_W'(DIV_2 - 1)) / PROD_W'(DIV_2);
    localparam logic [PROD_W-1:0] RECIP_3 =
        ((PROD_W'(1) << SH_3) + PROD_W'(DIV_3 - 1)) / PROD_W'(DIV_3);
    localparam logic [PROD_W-1:0] RECIP_4 =
        ((PROD_W'(1) << SH_4) + PROD_W'(DIV_4 - 1)) / PROD_W'(DIV_4);
    localparam logic [PROD_W-1:0] RECIP_5 =
        ((PROD_W'(1) << SH_5) + PROD_W'(DIV_5 - 1)) / PROD_W'(DIV_5);
    localparam logic [PROD_W-1:0] RECIP_6 =
        ((PROD_W'(1) << SH_6) + PROD_W'(DIV_6 - 1)) / PROD_W'(DIV_6);

    localparam t_div DIV_TAB [MAX_STEPS] = '{
        '{half: 7'(DIV_0 / 2), recip: RECIP_0[OPND_W-1:0], shift: 7'(SH_0)},
        '{half: 7'(DIV_1 / 2), recip: RECIP_1[OPND_W-1:0], shift: 7'(SH_1)},
        '{half: 7'(DIV_2 / 2), recip: RECIP_2[OPND_W-1:0], shift: 7'(SH_2)},
        '{half: 7'(DIV_3 / 2), recip: RECIP_3[OPND_W-1:0], shift: 7'(SH_3)},
        '{half: 7'(DIV_4 / 2), recip: RECIP_4[OPND_W-1:0], shift: 7'(SH_4)},
        '{half: 7'(DIV_5 / 2), recip: RECIP_5[OPND_W-1:0], shift: 7'(SH_5)},
        '{half: 7'(DIV_6 / 2), recip: RECIP_6[OPND_W-1:0], shift: 7'(SH_6)}
    };

endpackage

`default_nettype wire

// ===== rtl/tsa_square.sv =====
// Input stages: sign/magnitude split of the angle, then its exact square.
// Depends on tsa_pkg.
`default_nettype none

module tsa_square (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [tsa_pkg::ANGLE_W-1:0]   i_angle,
    output      logic                          o_valid,
    output      tsa_pkg::t_side                o_side
);

    logic                        r_v1;
    logic                        r_neg1;
    logic [tsa_pkg::ANGLE_W-1:0] r_mag1;
    logic                        r_v2;
    tsa_pkg::t_side              r_side;

    logic [tsa_pkg::ANGLE_W-1:0] n_mag1;
    logic [2*tsa_pkg::ANGLE_W-1:0] w_sq;

    // most negative angle maps to magnitude 2^31, which fits unsigned
    assign n_mag1 = i_angle[tsa_pkg::ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign w_sq   = (2*tsa_pkg::ANGLE_W)'(r_mag1) * (2*tsa_pkg::ANGLE_W)'(r_mag1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1       <= i_angle[tsa_pkg::ANGLE_W-1];
            r_mag1       <= n_mag1;
            r_side.x_neg <= r_neg1;
            r_side.x_mag <= r_mag1;
            r_side.x2    <= w_sq[tsa_pkg::MAG_W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/tsa_mag_mul.sv =====
// Two-stage 64x64 unsigned multiplier: four 32x32 partial products, then their sum.
// Carries a sign bit and the sample lane alongside. Depends on tsa_pkg.
`default_nettype none

module tsa_mag_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [tsa_pkg::OPND_W-1:0]    i_a,
    input  wire logic [tsa_pkg::OPND_W-1:0]    i_b,
    input  wire logic                          i_neg,
    input  wire tsa_pkg::t_side                i_side,
    output      logic                          o_valid,
    output      logic [tsa_pkg::PROD_W-1:0]    o_prod,
    output      logic                          o_neg,
    output      tsa_pkg::t_side                o_side
);

    localparam int HW = tsa_pkg::OPND_W / 2;

    logic                         r_v1;
    logic                         r_v2;
    logic [tsa_pkg::OPND_W-1:0]   r_p00;
    logic [tsa_pkg::OPND_W-1:0]   r_p01;
    logic [tsa_pkg::OPND_W-1:0]   r_p10;
    logic [tsa_pkg::OPND_W-1:0]   r_p11;
    logic                         r_neg1;
    logic                         r_neg2;
    tsa_pkg::t_side               r_side1;
    tsa_pkg::t_side               r_side2;
    logic [tsa_pkg::PROD_W-1:0]   r_prod;
    logic [tsa_pkg::PROD_W-1:0]   n_prod;

    assign n_prod = tsa_pkg::PROD_W'(r_p00)
                  + (tsa_pkg::PROD_W'(r_p01) << HW)
                  + (tsa_pkg::PROD_W'(r_p10) << HW)
                  + (tsa_pkg::PROD_W'(r_p11) << tsa_pkg::OPND_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= tsa_pkg::OPND_W'(i_a[HW-1:0]) * tsa_pkg::OPND_W'(i_b[HW-1:0]);
            r_p01   <= tsa_pkg::OPND_W'(i_a[HW-1:0]) * tsa_pkg::OPND_W'(i_b[2*HW-1:HW]);
            r_p10   <= tsa_pkg::OPND_W'(i_a[2*HW-1:HW]) * tsa_pkg::OPND_W'(i_b[HW-1:0]);
            r_p11   <= tsa_pkg::OPND_W'(i_a[2*HW-1:HW]) * tsa_pkg::OPND_W'(i_b[2*HW-1:HW]);
            r_neg1  <= i_neg;
            r_side1 <= i_side;
            r_prod  <= n_prod;
            r_neg2  <= r_neg1;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_neg   = r_neg2;
    assign o_side  = r_side2;

endmodule

`default_nettype wire

// ===== rtl/tsa_horner_step.sv =====
// One Horner step, six stages: inner' = 1 - round(round(x^2*inner)/((n-1)*n)).
// Values travel as sign and magnitude. Depends on tsa_pkg and tsa_mag_mul.
`default_nettype none

module tsa_horner_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire tsa_pkg::t_div                 i_div,
    input  wire logic                          i_valid,
    input  wire tsa_pkg::t_side                i_side,
    input  wire logic                          i_inner_neg,
    input  wire logic [tsa_pkg::MAG_W-1:0]     i_inner_mag,
    output      logic                          o_valid,
    output      tsa_pkg::t_side                o_side,
    output      logic                          o_inner_neg,
    output      logic [tsa_pkg::MAG_W-1:0]     o_inner_mag
);

    logic                         w_v_a;
    logic [tsa_pkg::PROD_W-1:0]   w_prod_a;
    logic                         w_neg_a;
    tsa_pkg::t_side               w_side_a;

    logic [tsa_pkg::PROD_W-1:0]   w_val;
    logic [tsa_pkg::MAG_W-1:0]    w_tmag;
    logic [tsa_pkg::OPND_W-1:0]   n_num;

    logic                         r_vc;
    logic [tsa_pkg::OPND_W-1:0]   r_num;
    logic                         r_negc;
    tsa_pkg::t_side               r_sidec;

    logic                         w_v_b;
    logic [tsa_pkg::PROD_W-1:0]   w_prod_b;
    logic                         w_neg_b;
    tsa_pkg::t_side               w_side_b;

    logic [tsa_pkg::PROD_W-1:0]   w_shifted;
    logic [tsa_pkg::MAG_W-1:0]    w_q;
    logic [tsa_pkg::OPND_W-1:0]   w_sum;
    logic [tsa_pkg::MAG_W-1:0]    w_diff;
    logic                         n_neg;
    logic [tsa_pkg::MAG_W-1:0]    n_mag;

    logic                         r_vf;
    logic                         r_negf;
    logic [tsa_pkg::MAG_W-1:0]    r_magf;
    tsa_pkg::t_side               r_sidef;

    // x^2 is never negative, so the product takes the sign of inner
    tsa_mag_mul u_mul_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_a     (tsa_pkg::OPND_W'(i_side.x2)),
        .i_b     (tsa_pkg::OPND_W'(i_inner_mag)),
        .i_neg   (i_inner_neg),
        .i_side  (i_side),
        .o_valid (w_v_a),
        .o_prod  (w_prod_a),
        .o_neg   (w_neg_a),
        .o_side  (w_side_a)
    );

    // round to nearest (ties away), drop fraction bits of x^2, clamp to 2^62,
    // then add half the divisor so the reciprocal product rounds the quotient
    assign w_val  = (w_prod_a + tsa_pkg::TERM_RND) >> tsa_pkg::TERM_SHIFT;
    assign w_tmag = (w_val > tsa_pkg::PROD_W'(tsa_pkg::LIM62)) ?
                    tsa_pkg::LIM62 : w_val[tsa_pkg::MAG_W-1:0];
    assign n_num  = tsa_pkg::OPND_W'(w_tmag) + tsa_pkg::OPND_W'(i_div.half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_vc <= w_v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= n_num;
            r_negc  <= w_neg_a;
            r_sidec <= w_side_a;
        end
    end

    tsa_mag_mul u_mul_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vc),
        .i_a     (r_num),
        .i_b     (i_div.recip),
        .i_neg   (r_negc),
        .i_side  (r_sidec),
        .o_valid (w_v_b),
        .o_prod  (w_prod_b),
        .o_neg   (w_neg_b),
        .o_side  (w_side_b)
    );

    // quotient magnitude, then 1 - t with the result clamped to +-2^62
    assign w_shifted = w_prod_b >> i_div.shift;
    assign w_q       = w_shifted[tsa_pkg::MAG_W-1:0];
    assign w_sum     = tsa_pkg::OPND_W'(tsa_pkg::ONE_INNER) + tsa_pkg::OPND_W'(w_q);
    assign w_diff    = w_q - tsa_pkg::ONE_INNER;

    always_comb begin
        if (w_neg_b) begin
            n_neg = 1'b0;
            n_mag = (w_sum > tsa_pkg::OPND_W'(tsa_pkg::LIM62)) ?
                    tsa_pkg::LIM62 : w_sum[tsa_pkg::MAG_W-1:0];
        end else if (w_q <= tsa_pkg::ONE_INNER) begin
            n_neg = 1'b0;
            n_mag = tsa_pkg::ONE_INNER - w_q;
        end else begin
            n_neg = 1'b1;
            n_mag = (w_diff > tsa_pkg::LIM62) ? tsa_pkg::LIM62 : w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_vf <= w_v_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_negf  <= n_neg;
            r_magf  <= n_mag;
            r_sidef <= w_side_b;
        end
    end

    assign o_valid     = r_vf;
    assign o_side      = r_sidef;
    assign o_inner_neg = r_negf;
    assign o_inner_mag = r_magf;

endmodule

`default_nettype wire

// ===== rtl/taylor_sine_approximator_unit.sv =====
// Degree-11 Taylor sine, Horner form: square stages, Horner steps, final product, output register.
// Throughput one angle per clock; the whole pipeline advances together, held only while
// the output register holds a result that is not taken. Synchronous active-low reset
// clears every stage valid bit; data registers are not reset. No state between samples.
// Depends on tsa_pkg, tsa_square, tsa_horner_step and tsa_mag_mul.
`default_nettype none

module taylor_sine_approximator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] angle, signed Q3.28 radians
    // output stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [31:0] o_m_axis_tdata,   // [31:0] sine_value, signed Q3.28
    output      logic        o_m_axis_tuser    // [0] overflow, result was saturated
);

    localparam int NS = tsa_pkg::NUM_STEPS;

    logic w_en;

    // chain between Horner steps; index 0 is the square stage output
    logic                         w_valid     [NS+1];
    tsa_pkg::t_side               w_side      [NS+1];
    logic                         w_inner_neg [NS+1];
    logic [tsa_pkg::MAG_W-1:0]    w_inner_mag [NS+1];

    logic                         w_fin_valid;
    logic [tsa_pkg::PROD_W-1:0]   w_fin_prod;
    logic                         w_fin_neg;

    logic [tsa_pkg::PROD_W-1:0]   w_rval;
    logic [31:0]                  n_data;
    logic                         n_ovf;

    logic                         r_out_valid;
    logic [31:0]                  r_out_data;
    logic                         r_out_ovf;

    // Advance every stage unless the output register is full and stalled.
    // Bubbles are not squeezed out, but an empty output slot never blocks.
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    tsa_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_angle (i_s_axis_tdata),
        .o_valid (w_valid[0]),
        .o_side  (w_side[0])
    );

    // the innermost Horner value starts at exactly one
    assign w_inner_neg[0] = 1'b0;
    assign w_inner_mag[0] = tsa_pkg::ONE_INNER;

    // One step per odd exponent, from the top term down to x^3.
    for (genvar g = 0; g < NS; g++) begin : g_step
        tsa_horner_step u_step (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_div       (tsa_pkg::DIV_TAB[g]),
            .i_valid     (w_valid[g]),
            .i_side      (w_side[g]),
            .i_inner_neg (w_inner_neg[g]),
            .i_inner_mag (w_inner_mag[g]),
            .o_valid     (w_valid[g+1]),
            .o_side      (w_side[g+1]),
            .o_inner_neg (w_inner_neg[g+1]),
            .o_inner_mag (w_inner_mag[g+1])
        );
    end

    // Final product x * inner, two stages.
    tsa_mag_mul u_mul_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[NS]),
        .i_a     (tsa_pkg::OPND_W'(w_inner_mag[NS])),
        .i_b     (tsa_pkg::OPND_W'(w_side[NS].x_mag)),
        .i_neg   (w_inner_neg[NS] ^ w_side[NS].x_neg),
        .i_side  (w_side[NS]),
        .o_valid (w_fin_valid),
        .o_prod  (w_fin_prod),
        .o_neg   (w_fin_neg),
        .o_side  ()
    );

    // Round away from zero on the dropped inner fraction bits, then saturate to
    // the 32-bit range. The 2^62 clamp of the product is moot here: anything
    // that large already saturates the output.
    assign w_rval = (w_fin_prod + tsa_pkg::FIN_RND) >> tsa_pkg::INNER_FRAC;

    always_comb begin
        if (w_fin_neg) begin
            if (w_rval > (tsa_pkg::PROD_W'(1) << 31)) begin
                n_data = 32'h8000_0000;
                n_ovf  = 1'b1;
            end else begin
                n_data = ~w_rval[31:0] + 32'd1;
                n_ovf  = 1'b0;
            end
        end else begin
            if (w_rval > tsa_pkg::PROD_W'(32'h7FFF_FFFF)) begin
                n_data = 32'h7FFF_FFFF;
                n_ovf  = 1'b1;
            end else begin
                n_data = w_rval[31:0];
                n_ovf  = 1'b0;
            end
        end
    end

    // Output register: holds the transfer until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_data;
            r_out_ovf  <= n_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_ovf;

    // Overflow only ever comes with a value pinned at one of the range limits.
    a_ovf_saturates : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (o_m_axis_tdata == 32'h7FFF_FFFF || o_m_axis_tdata == 32'h8000_0000))
        else $error("overflow flagged on an unsaturated result");

    // A held pipeline keeps its samples in place.
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid[NS]) && $stable(w_fin_valid))
        else $error("pipeline valid moved during a stall");

    // The last Horner value never exceeds the 2^62 clamp.
    a_inner_clamped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NS] |-> (w_inner_mag[NS] <= tsa_pkg::LIM62))
        else $error("Horner magnitude above clamp");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the degree-11 Taylor sine pipeline.
// Holds its own fixed-point Horner predictor; depends on the RTL and tsa_pkg only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_LIMIT = 3000;     // cycles without any transfer
    localparam int     SETTLE     = 60;       // settling wait after the final drain
    localparam longint MAG_CLAMP  = longint'(1) << 62;
    localparam longint INNER_ONE  = longint'(1) << tsa_pkg::INNER_FRAC;

    // Common angles in Q3.28
    localparam logic [31:0] HALF_PI_Q = 32'h1921_FB54;
    localparam logic [31:0] PI_Q      = 32'h3243_F6A9;
    localparam logic [31:0] TWO_PI_Q  = 32'h6487_ED51;
    localparam logic [31:0] ONE_Q     = 32'h1000_0000;

    typedef struct {
        logic [31:0] sine;
        logic        ovf;
    } sine_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_angle = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    sine_result_t sine_due_q[$];
    int  error_count   = 0;
    int  angles_sent   = 0;
    int  results_seen  = 0;
    int  overflow_seen = 0;
    int  idle_cycles   = 0;
    bit  calm          = 1'b0;     // when set, both sides run with no gaps

    taylor_sine_approximator_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_angle),          // [31:0] angle
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] sine_value
        .o_m_axis_tuser  (o_m_axis_tuser)    // [0] overflow
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // round(a*b / 2^s), ties away from zero, magnitude clamped at 2^62
    function automatic longint scaled_product(input longint a, input longint b, input int s);
        logic         neg;
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] full;
        neg   = (a < 0) != (b < 0);
        mag_a = (a < 0) ? 64'(0) - 64'(a) : 64'(a);
        mag_b = (b < 0) ? 64'(0) - 64'(b) : 64'(b);
        full  = ({64'd0, mag_a} * {64'd0, mag_b} + (128'd1 << (s - 1))) >> s;
        if (full > 128'(MAG_CLAMP))
            full = 128'(MAG_CLAMP);
        return neg ? -longint'(full[63:0]) : longint'(full[63:0]);
    endfunction

    // round(v / d), ties away from zero, d positive and even here
    function automatic longint rounded_quotient(input longint v, input longint d);
        logic [63:0] mag;
        logic [63:0] quo;
        mag = (v < 0) ? 64'(0) - 64'(v) : 64'(v);
        quo = (mag + 64'(d / 2)) / 64'(d);
        return (v < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // Horner evaluation: inner = 1 - x^2*inner/((n-1)n) from the top term down,
    // then sine = x*inner, saturated to the 32-bit range.
    function automatic sine_result_t taylor_sine(input logic [31:0] raw);
        sine_result_t res;
        longint x;
        longint x_sq;
        longint inner;
        longint term;
        longint sine;
        int     n;
        x     = longint'($signed(raw));
        x_sq  = x * x;
        inner = INNER_ONE;
        for (n = tsa_pkg::TOP_ODD; n >= 3; n -= 2) begin
            term  = scaled_product(x_sq, inner, 2 * tsa_pkg::FRAC_BITS);
            term  = rounded_quotient(term, longint'((n - 1) * n));
            inner = INNER_ONE - term;
            if (inner > MAG_CLAMP)
                inner = MAG_CLAMP;
            else if (inner < -MAG_CLAMP)
                inner = -MAG_CLAMP;
        end
        sine    = scaled_product(inner, x, tsa_pkg::INNER_FRAC);
        res.ovf = 1'b0;
        if (sine > longint'(32'sh7FFF_FFFF)) begin
            sine    = longint'(32'sh7FFF_FFFF);
            res.ovf = 1'b1;
        end else if (sine < -longint'(32'sh7FFF_FFFF) - 1) begin
            sine    = -longint'(32'sh7FFF_FFFF) - 1;
            res.ovf = 1'b1;
        end
        res.sine = sine[31:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Predict on every input transfer, then compare every output transfer
    // with the oldest prediction. One process, so the order is fixed.
    always @(posedge i_clk) begin
        sine_result_t due;
        if (i_rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (s_valid && o_s_axis_tready) begin
                sine_due_q.push_back(taylor_sine(s_angle));
                angles_sent++;
            end

            if (o_m_axis_tvalid && m_ready) begin
                results_seen++;
                if (o_m_axis_tuser)
                    overflow_seen++;
                if (sine_due_q.size() == 0) begin
                    report_mismatch("result with nothing pending", o_m_axis_tdata, '0);
                end else begin
                    due = sine_due_q.pop_front();
                    if (o_m_axis_tdata !== due.sine)
                        report_mismatch("sine_value", o_m_axis_tdata, due.sine);
                    if (o_m_axis_tuser !== due.ovf)
                        report_mismatch("overflow", 32'(o_m_axis_tuser), 32'(due.ovf));
                end
            end

            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles without a transfer, %0d results pending",
                         idle_cycles, sine_due_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: insert a random tready-low gap before each transfer, unless calm is set.
    initial begin
        int wait_cycles;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = calm ? 0 : $urandom_range(0, 4);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && m_ready));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Send one angle; called and returns at a falling edge.
    task automatic send_angle(input logic [31:0] angle);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_angle <= angle;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Hold the sender until every pending result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sine_due_q.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] angle_within(input logic [31:0] bound);
        return 32'($urandom_range(0, 2 * bound)) - bound;
    endfunction

    function automatic logic [31:0] random_angle();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return angle_within(PI_Q);
            4, 5:       return angle_within(TWO_PI_Q);
            6, 7:       return $urandom();
            8: begin
                // tiny angles around zero
                mag = $urandom() >> $urandom_range(4, 31);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: begin
                // 4..8 rad, where the series starts to leave the range
                mag = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    // Zero, one LSB, the extremes of the field, the usual angles, and
    // large angles that force saturation both ways.
    task automatic test_directed_angles();
        logic [31:0] angles[$];
        angles = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                   ONE_Q, -ONE_Q, HALF_PI_Q, -HALF_PI_Q,
                   PI_Q, -PI_Q, TWO_PI_Q, -TWO_PI_Q,
                   32'h4000_0000, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h0000_0100, 32'hFFFF_FF00, 32'h6000_0000, 32'hA000_0000};
        foreach (angles[i])
            send_angle(angles[i]);
        drain_results();
    endtask

    // Back-to-back transfers on both sides.
    task automatic test_full_rate(input int count);
        calm = 1'b1;
        repeat (count)
            send_angle(random_angle());
        drain_results();
        calm = 1'b0;
    endtask

    // Random angles with random gaps and stalls, gap-free stretches now and
    // then, and a full drain every few hundred angles.
    task automatic test_random_angles(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i % 350 == 349)
                drain_results();
            send_angle(random_angle());
        end
        calm = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_angles();
        test_full_rate(150);
        test_random_angles(1250);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sine_due_q.size() != 0)
            report_mismatch("results never returned", 32'(sine_due_q.size()), '0);

        $display("covered %0d angles over the whole Q3.28 field, %0d results checked,",
                 angles_sent, results_seen);
        $display("%0d of them saturated; gaps and stalls of 0..4 cycles", overflow_seen);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
